@@ rtl/clc_pkg.sv @@
// Package for the circular list block: field widths, request and status codes,
// and default sizes for the node pool.
// It has no dependencies.
package clc_pkg;

	localparam int POOL_NODES_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 9;

	typedef logic [REQ_W-1:0]    req_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam req_t REQ_INS_TAIL  = 3'd0;
	localparam req_t REQ_INS_FRONT = 3'd1;
	localparam req_t REQ_FIRST     = 3'd2;
	localparam req_t REQ_NEXT      = 3'd3;
	localparam req_t REQ_REMOVE    = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EMPTY     = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NO_CURSOR = 2'd3;

endpackage

@@ rtl/circular_list_with_cursor.sv @@
// Circular singly linked list with a traversal cursor, kept in a link memory and a
// value memory of POOL_NODES entries, with list pointers and free-chain head in registers.
// Depends on clc_pkg.
//
// One request word is worked on at a time and gives exactly one result word. A request
// that ends in an error status, an unused request code, an insert into an empty list and
// the removal of the last node finish in S_LINK; first and next go on to S_VAL because
// the value read depends on the link just read, and the other inserts and removes go on
// to S_WR2 because they rewrite two links through the link memory's single write port.
// A new request word is taken in the cycle after the result is registered, even while
// it waits in the output register, but not while it waits in the hold register. Both
// memories start undefined and need no clearing: no unwritten entry's value is ever used.
module circular_list_with_cursor
	import clc_pkg::*;
#(
	parameter int POOL_NODES = POOL_NODES_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req_type,
	input  logic [DATA_W-1:0]   data_in,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output status_t             status,
	output logic [DATA_W-1:0]   data_out,
	output logic [COUNT_W-1:0]  count
);

	localparam int NW = $clog2(POOL_NODES);
	localparam int CW = $clog2(POOL_NODES + 1);

	typedef logic [NW-1:0] node_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LINK = 4'b0010,
		S_VAL  = 4'b0100,
		S_WR2  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	node_t  tail_q, tail_d;
	node_t  cursor_q, cursor_d;
	node_t  prior_q, prior_d;
	logic   empty_q, empty_d;
	cnt_t   count_q, count_d;
	logic   rm_allowed_q, rm_allowed_d;
	logic   cur_valid_q, cur_valid_d;
	node_t  free_head_q, free_head_d;
	cnt_t   free_len_q, free_len_d;
	cnt_t   fresh_q, fresh_d;

	req_t                op_q;
	logic [DATA_W-1:0]   din_q;
	node_t               lnk_a_q, lnk_b_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	node_t               wr2_addr_q, wr2_addr_d;
	node_t               wr2_data_q, wr2_data_d;
	logic [DATA_W-1:0]   dv_q, dv_d;

	logic                  rsp_valid_q, hold_valid_q;
	status_t               out_status_q, hold_status_q;
	logic [DATA_W-1:0]     out_data_q, hold_data_q;
	logic [COUNT_W-1:0]    out_count_q, hold_count_q;

	node_t link_mem [POOL_NODES];
	logic [VALUE_BITS-1:0] val_mem [POOL_NODES];

	logic                  acc;
	logic                  out_free;
	node_t                 rd_b_addr;
	node_t                 new_node;
	logic                  full;
	logic [VALUE_BITS+DATA_W-1:0] din_ext;
	logic [VALUE_BITS+DATA_W-1:0] val_out_ext;
	logic [DATA_W-1:0]     val_dout;
	logic [CW+COUNT_W-1:0] cnt_ext;

	logic                  link_we;
	node_t                 link_waddr;
	node_t                 link_wdata;
	logic                  val_we;
	logic                  val_re;
	node_t                 val_raddr;

	logic                  fin;
	status_t               fin_status;
	logic [DATA_W-1:0]     fin_data;

	assign req_stall = (state_q != S_IDLE) || hold_valid_q;
	assign acc       = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rd_b_addr = (req_type == REQ_NEXT || req_type == REQ_REMOVE) ? cursor_q : tail_q;
	assign new_node  = (free_len_q != '0) ? free_head_q : fresh_q[NW-1:0];
	assign full      = (count_q == cnt_t'(POOL_NODES));

	assign din_ext     = {{VALUE_BITS{1'b0}}, din_q};
	assign val_out_ext = {{DATA_W{1'b0}}, val_rd_q};
	assign val_dout    = val_out_ext[DATA_W-1:0];
	assign cnt_ext     = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_waddr] <= link_wdata;
		if (acc) begin
			lnk_a_q <= link_mem[free_head_q];
			lnk_b_q <= link_mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we)
			val_mem[new_node] <= din_ext[VALUE_BITS-1:0];
		if (val_re)
			val_rd_q <= val_mem[val_raddr];
	end

	always_comb begin
		state_d      = state_q;
		tail_d       = tail_q;
		cursor_d     = cursor_q;
		prior_d      = prior_q;
		empty_d      = empty_q;
		count_d      = count_q;
		rm_allowed_d = rm_allowed_q;
		cur_valid_d  = cur_valid_q;
		free_head_d  = free_head_q;
		free_len_d   = free_len_q;
		fresh_d      = fresh_q;
		wr2_addr_d   = wr2_addr_q;
		wr2_data_d   = wr2_data_q;
		dv_d         = dv_q;
		link_we      = 1'b0;
		link_waddr   = wr2_addr_q;
		link_wdata   = wr2_data_q;
		val_we       = 1'b0;
		val_re       = 1'b0;
		val_raddr    = cursor_q;
		fin          = 1'b0;
		fin_status   = ST_OK;
		fin_data     = dv_q;

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = S_LINK;
					val_re  = 1'b1;
				end
			end
			S_LINK: begin
				fin      = 1'b1;
				fin_data = '0;
				state_d  = S_IDLE;
				case (op_q)
					REQ_INS_TAIL, REQ_INS_FRONT: begin
						if (full) begin
							fin_status = ST_FULL;
						end else begin
							val_we     = 1'b1;
							link_we    = 1'b1;
							link_waddr = new_node;
							link_wdata = empty_q ? new_node : lnk_b_q;
							if (free_len_q != '0) begin
								free_head_d = lnk_a_q;
								free_len_d  = free_len_q - cnt_t'(1);
							end else begin
								fresh_d = fresh_q + cnt_t'(1);
							end
							count_d      = count_q + cnt_t'(1);
							rm_allowed_d = 1'b0;
							if (empty_q) begin
								tail_d  = new_node;
								empty_d = 1'b0;
							end else begin
								if (op_q == REQ_INS_TAIL)
									tail_d = new_node;
								fin        = 1'b0;
								state_d    = S_WR2;
								wr2_addr_d = tail_q;
								wr2_data_d = new_node;
								dv_d       = '0;
							end
						end
					end
					REQ_FIRST: begin
						if (empty_q) begin
							fin_status = ST_EMPTY;
						end else begin
							prior_d      = tail_q;
							cursor_d     = lnk_b_q;
							cur_valid_d  = 1'b1;
							rm_allowed_d = 1'b1;
							val_re       = 1'b1;
							val_raddr    = lnk_b_q;
							fin          = 1'b0;
							state_d      = S_VAL;
						end
					end
					REQ_NEXT: begin
						if (empty_q) begin
							fin_status = ST_EMPTY;
						end else if (!cur_valid_q) begin
							fin_status = ST_NO_CURSOR;
						end else begin
							prior_d      = cursor_q;
							cursor_d     = lnk_b_q;
							rm_allowed_d = 1'b1;
							val_re       = 1'b1;
							val_raddr    = lnk_b_q;
							fin          = 1'b0;
							state_d      = S_VAL;
						end
					end
					REQ_REMOVE: begin
						if (!rm_allowed_q || empty_q) begin
							fin_status = ST_NO_CURSOR;
						end else begin
							fin_data     = val_dout;
							cursor_d     = prior_q;
							free_head_d  = cursor_q;
							free_len_d   = free_len_q + cnt_t'(1);
							count_d      = count_q - cnt_t'(1);
							rm_allowed_d = 1'b0;
							link_we      = 1'b1;
							if (count_q <= cnt_t'(1)) begin
								empty_d     = 1'b1;
								cur_valid_d = 1'b0;
								tail_d      = '0;
								link_waddr  = cursor_q;
								link_wdata  = free_head_q;
							end else begin
								if (cursor_q == tail_q)
									tail_d = prior_q;
								link_waddr = prior_q;
								link_wdata = lnk_b_q;
								fin        = 1'b0;
								state_d    = S_WR2;
								wr2_addr_d = cursor_q;
								wr2_data_d = free_head_q;
								dv_d       = val_dout;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_VAL: begin
				fin      = 1'b1;
				fin_data = val_dout;
				state_d  = S_IDLE;
			end
			S_WR2: begin
				link_we = 1'b1;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tail_q       <= '0;
			cursor_q     <= '0;
			prior_q      <= '0;
			empty_q      <= 1'b1;
			count_q      <= '0;
			rm_allowed_q <= 1'b0;
			cur_valid_q  <= 1'b0;
			free_head_q  <= '0;
			free_len_q   <= '0;
			fresh_q      <= '0;
		end else begin
			state_q      <= state_d;
			tail_q       <= tail_d;
			cursor_q     <= cursor_d;
			prior_q      <= prior_d;
			empty_q      <= empty_d;
			count_q      <= count_d;
			rm_allowed_q <= rm_allowed_d;
			cur_valid_q  <= cur_valid_d;
			free_head_q  <= free_head_d;
			free_len_q   <= free_len_d;
			fresh_q      <= fresh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= req_type;
			din_q <= data_in;
		end
		wr2_addr_q <= wr2_addr_d;
		wr2_data_q <= wr2_data_d;
		dv_q       <= dv_d;
	end

	// The result word goes to the output register when it is free, else to the hold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (fin) begin
			if (out_free)
				rsp_valid_q <= 1'b1;
			else
				hold_valid_q <= 1'b1;
		end else if (out_free) begin
			rsp_valid_q  <= hold_valid_q;
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && out_free) begin
			out_status_q <= fin_status;
			out_data_q   <= fin_data;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
		end else if (!fin && out_free && hold_valid_q) begin
			out_status_q <= hold_status_q;
			out_data_q   <= hold_data_q;
			out_count_q  <= hold_count_q;
		end
		if (fin && !out_free) begin
			hold_status_q <= fin_status;
			hold_data_q   <= fin_data;
			hold_count_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = out_status_q;
	assign data_out  = out_data_q;
	assign count     = out_count_q;

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (count_q == '0))
		else $error("empty flag disagrees with node count");

	a_nodes_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} + {1'b0, free_len_q}) == {1'b0, fresh_q})
		else $error("listed and free nodes do not add up to the nodes taken");

	a_remove_needs_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rm_allowed_q |-> (cur_valid_q && !empty_q))
		else $error("remove right set without a valid cursor");

	a_hold_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> rsp_valid_q)
		else $error("hold register full while output register is empty");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(POOL_NODES))
		else $error("node count exceeds pool size");

endmodule

@@ bench/circular_list_checker.sv @@
// Checker for the circular list block: watches both channels, predicts every result word
// from its own copy of the list and compares it field by field in order of arrival.
// Depends on clc_pkg.
module circular_list_checker
	import clc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  req_t                req_type,
	input  logic [DATA_W-1:0]   data_in,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  status_t             status,
	input  logic [DATA_W-1:0]   data_out,
	input  logic [COUNT_W-1:0]  count,
	output int                  fails,
	output int                  outstanding
);

	localparam int POOL   = POOL_NODES_DEF;
	localparam int NODE_W = $clog2(POOL);

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		status_t              st;
		logic [DATA_W-1:0]    value;
		logic [COUNT_W-1:0]   nodes;
	} list_reply_t;

	list_reply_t replies_due[$];

	logic [DATA_W-1:0]  val_mem [0:POOL-1];
	node_t              nxt_mem [0:POOL-1];
	node_t              tail_at;
	node_t              cursor_at;
	node_t              prior_at;
	node_t              free_top;
	logic               is_empty;
	logic               may_remove;
	logic               cursor_ok;
	logic [COUNT_W-1:0] live_nodes;
	logic [COUNT_W-1:0] free_len;
	logic [COUNT_W-1:0] fresh_used;

	initial fails = 0;
	initial outstanding = 0;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t circular_list_checker: %s got %0h want %0h", $time, what, got, want);
		fails++;
	endtask

	task automatic apply_request(input req_t rq, input logic [DATA_W-1:0] din,
			output status_t st, output logic [DATA_W-1:0] dv);
		node_t n;
		node_t r;
		st = ST_OK;
		dv = '0;
		case (rq)
			REQ_INS_TAIL, REQ_INS_FRONT: begin
				if (live_nodes >= POOL) begin
					st = ST_FULL;
				end else begin
					if (free_len != 0) begin
						n = free_top;
						free_top = nxt_mem[n];
						free_len--;
					end else begin
						n = fresh_used[NODE_W-1:0];
						fresh_used++;
					end
					val_mem[n] = din;
					if (is_empty) begin
						nxt_mem[n] = n;
						tail_at = n;
						is_empty = 1'b0;
					end else begin
						nxt_mem[n] = nxt_mem[tail_at];
						nxt_mem[tail_at] = n;
						if (rq == REQ_INS_TAIL)
							tail_at = n;
					end
					live_nodes++;
					may_remove = 1'b0;
				end
			end
			REQ_FIRST: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else begin
					prior_at = tail_at;
					cursor_at = nxt_mem[prior_at];
					cursor_ok = 1'b1;
					may_remove = 1'b1;
					dv = val_mem[cursor_at];
				end
			end
			REQ_NEXT: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else if (!cursor_ok) begin
					st = ST_NO_CURSOR;
				end else begin
					prior_at = cursor_at;
					cursor_at = nxt_mem[prior_at];
					may_remove = 1'b1;
					dv = val_mem[cursor_at];
				end
			end
			REQ_REMOVE: begin
				if (!may_remove || is_empty) begin
					st = ST_NO_CURSOR;
				end else begin
					r = cursor_at;
					dv = val_mem[r];
					if (live_nodes <= 1) begin
						is_empty = 1'b1;
						cursor_ok = 1'b0;
						tail_at = '0;
					end else begin
						if (r == tail_at)
							tail_at = prior_at;
						nxt_mem[prior_at] = nxt_mem[r];
					end
					cursor_at = prior_at;
					nxt_mem[r] = free_top;
					free_top = r;
					free_len++;
					live_nodes--;
					may_remove = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		list_reply_t due;
		status_t     st;
		logic [DATA_W-1:0] dv;
		if (!arst_n) begin
			tail_at = '0;
			cursor_at = '0;
			prior_at = '0;
			free_top = '0;
			is_empty = 1'b1;
			may_remove = 1'b0;
			cursor_ok = 1'b0;
			live_nodes = '0;
			free_len = '0;
			fresh_used = '0;
		end else begin
			// The result leaving now always belongs to an earlier request word.
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected word, status", DATA_W'(status), '0);
				end else begin
					due = replies_due.pop_front();
					if (status !== due.st)
						report_mismatch("status", DATA_W'(status), DATA_W'(due.st));
					if (data_out !== due.value)
						report_mismatch("data_out", data_out, due.value);
					if (count !== due.nodes)
						report_mismatch("count", DATA_W'(count), DATA_W'(due.nodes));
				end
			end
			if (req_valid && !req_stall) begin
				apply_request(req_type, data_in, st, dv);
				due.st = st;
				due.value = dv;
				due.nodes = live_nodes;
				replies_due.push_back(due);
			end
		end
		outstanding <= replies_due.size();
	end

endmodule

@@ bench/circular_list_with_cursor_tb.sv @@
// Testbench top for the circular list block: drives request words with random gaps and
// random result stalls; the verdict comes from the checker's fails or a timeout.
// Depends on clc_pkg, circular_list_with_cursor and circular_list_checker.
module circular_list_with_cursor_tb;
	import clc_pkg::*;

	localparam req_t REQ_SPARE_FIRST = 3'd5;
	localparam req_t REQ_SPARE_LAST  = 3'd7;
	localparam int   CYCLE_LIMIT     = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req_type = REQ_INS_TAIL;
	logic [DATA_W-1:0]  data_in = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	status_t            status;
	logic [DATA_W-1:0]  data_out;
	logic [COUNT_W-1:0] count;

	int   fails;
	int   outstanding;
	int   cycles = 0;
	int   words_sent = 0;
	logic calm_sender = 1'b0;
	int   words_taken = 0;
	logic calm_receiver = 1'b0;
	int   hold_left = 0;

	always #1 clk = ~clk;

	circular_list_with_cursor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.data_in   (data_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data_out  (data_out),
		.count     (count)
	);

	circular_list_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.data_in     (data_in),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.data_out    (data_out),
		.count       (count),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("circular_list_with_cursor_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		int wait_cycles;
		if (rsp_valid && !rsp_stall) begin
			words_taken++;
			if (words_taken % 50 == 0)
				calm_receiver <= ($urandom_range(0, 2) == 0);
			wait_cycles = calm_receiver ? 0 : $urandom_range(0, 15);
			hold_left <= wait_cycles;
			rsp_stall <= (wait_cycles != 0);
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= (hold_left != 1);
		end
	end

	function automatic logic [DATA_W-1:0] pick_data();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic send_request(input req_t rq, input logic [DATA_W-1:0] d);
		int gap;
		if (words_sent % 50 == 0)
			calm_sender = ($urandom_range(0, 2) == 0);
		words_sent++;
		gap = calm_sender ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rq;
		data_in <= d;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	initial begin
		int   i;
		int   pick;
		logic drop_next;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_NEXT, 32'hFFFF_FFFF);
		send_request(REQ_FIRST, 32'h0000_0000);
		send_request(REQ_INS_TAIL, 32'h0000_0000);
		send_request(REQ_NEXT, 32'h1234_5678);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_INS_FRONT, 32'hFFFF_FFFF);
		send_request(REQ_INS_TAIL, 32'h5A5A_A5A5);
		send_request(REQ_FIRST, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'hFFFF_FFFF);
		send_request(REQ_NEXT, 32'h0000_0000);
		send_request(REQ_NEXT, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_FIRST, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_FIRST, 32'h0000_0000);
		send_request(REQ_SPARE_FIRST, 32'hFFFF_FFFF);
		send_request(req_t'(REQ_SPARE_FIRST + 1), 32'h0000_0000);
		send_request(REQ_SPARE_LAST, 32'hFFFF_FFFF);
		send_request(REQ_INS_TAIL, 32'h8000_0001);
		send_request(REQ_INS_FRONT, 32'h7FFF_FFFE);
		send_request(REQ_NEXT, 32'h0000_0000);
		send_request(REQ_FIRST, 32'h0000_0000);
		send_request(REQ_NEXT, 32'h0000_0000);

		// Fill the pool past its size so that full inserts occur.
		for (i = 0; i < 320; i++) begin
			if ($urandom_range(0, 9) != 0)
				send_request($urandom_range(0, 1) ? REQ_INS_TAIL : REQ_INS_FRONT,
					pick_data());
			else
				send_request(req_t'($urandom_range(REQ_FIRST, REQ_SPARE_LAST)), pick_data());
		end

		// Walk the list and remove visited nodes, with occasional tail inserts.
		drop_next = 1'b0;
		for (i = 0; i < 600; i++) begin
			if (drop_next) begin
				send_request(REQ_REMOVE, pick_data());
				drop_next = 1'b0;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_request(REQ_INS_TAIL, pick_data());
				else if (pick < 4)
					send_request(REQ_FIRST, pick_data());
				else
					send_request(REQ_NEXT, pick_data());
				drop_next = ($urandom_range(0, 9) < 7);
			end
		end

		for (i = 0; i < 580; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 3)
				send_request(REQ_INS_TAIL, pick_data());
			else if (pick < 6)
				send_request(REQ_INS_FRONT, pick_data());
			else if (pick < 8)
				send_request(REQ_FIRST, pick_data());
			else if (pick < 13)
				send_request(REQ_NEXT, pick_data());
			else if (pick < 19)
				send_request(REQ_REMOVE, pick_data());
			else
				send_request(req_t'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
					pick_data());
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("circular_list_with_cursor_tb: done, clean");
		else
			$display("circular_list_with_cursor_tb: done, errors");
		$finish;
	end

endmodule
